@@ hw/rtl/two_line_text_terminal_scroller_unit_assert.svh @@
// Assertion macros used by the terminal scroller sequencer.
`ifndef TWO_LINE_TEXT_TERMINAL_SCROLLER_UNIT_ASSERT_SVH
`define TWO_LINE_TEXT_TERMINAL_SCROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tlts_pkg.sv @@
// Shared constants, types and helpers of the two-row terminal scroller.
package tlts_pkg;

  localparam int COLUMNS     = 16;
  localparam int DEPTH       = 2 * COLUMNS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CUR_W       = $clog2(COLUMNS);
  localparam int CHAR_W      = 8;
  localparam int COL_FIELD_W = 4;

  localparam logic [CHAR_W-1:0] CR_CHAR    = 8'h0D;
  localparam logic [CHAR_W-1:0] LF_CHAR    = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic CMD_SET_POS = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  localparam logic [CUR_W-1:0] LAST_COL = CUR_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR_POS,
    S_CUR_CHAR,
    S_R0_POS,
    S_R0_CHAR,
    S_R1_POS,
    S_R1_CHAR,
    S_END_POS
  } seq_state_t;

  // Control from the sequencer to the text store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              clr;
    logic              clr_row;
    logic [ADDR_W-1:0] raddr;
  } st_ctl_t;

  // One display command word.
  typedef struct packed {
    logic                   command;
    logic [COL_FIELD_W-1:0] column;
    logic                   row;
    logic [CHAR_W-1:0]      char_out;
    logic                   last;
  } cmd_t;

  // Physical store address of a column in a physical row.
  function automatic logic [ADDR_W-1:0] entry_addr(input logic prow,
                                                   input logic [CUR_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = prow ? ADDR_W'(COLUMNS) : '0;
    return base + ADDR_W'(col);
  endfunction

  // Column as reported in the 4-bit command field.
  function automatic logic [COL_FIELD_W-1:0] col_field(input logic [CUR_W-1:0] col);
    logic [CUR_W+COL_FIELD_W-1:0] wide;
    wide = {{COL_FIELD_W{1'b0}}, col};
    return wide[COL_FIELD_W-1:0];
  endfunction

endpackage

@@ hw/rtl/tlts_store.sv @@
// Text store: character memory with per-entry valid bits and a registered read.
module tlts_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlts_pkg::st_ctl_t            ctl,
  output logic [tlts_pkg::CHAR_W-1:0]  rd_char
);

  logic [tlts_pkg::CHAR_W-1:0] mem [tlts_pkg::DEPTH];
  logic [tlts_pkg::DEPTH-1:0]  vld_r;
  logic [tlts_pkg::CHAR_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  // Write the typed character, read the next entry the sequencer needs
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rd_data_r <= mem[ctl.raddr];
  end

  // Track written entries; a cleared row reads back as spaces
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      for (int i = 0; i < tlts_pkg::DEPTH; i++) begin
        if (ctl.clr && ((i >= tlts_pkg::COLUMNS) == ctl.clr_row)) begin
          vld_r[i] <= 1'b0;
        end
      end
      if (ctl.we) begin
        vld_r[ctl.waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[ctl.raddr];
    end
  end

  assign rd_char = rd_vld_r ? rd_data_r : tlts_pkg::SPACE_CHAR;

endmodule

@@ hw/rtl/tlts_seq.sv @@
// Command sequencer: cursor, row mapping and the display command walk.
`include "two_line_text_terminal_scroller_unit_assert.svh"

module tlts_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [tlts_pkg::CHAR_W-1:0]  in_char_in,
  output logic                         in_stall,
  input  logic                         take,
  input  logic [tlts_pkg::CHAR_W-1:0]  rd_char,
  output tlts_pkg::cmd_t               cmd,
  output logic                         cmd_valid,
  output tlts_pkg::st_ctl_t            st_ctl
);

  tlts_pkg::seq_state_t         state_r, state_nxt;
  logic [tlts_pkg::CUR_W-1:0]   col_r, col_nxt;
  logic [tlts_pkg::CUR_W-1:0]   cursor_r, cursor_nxt;
  logic                         base_r, base_nxt;
  logic [tlts_pkg::CHAR_W-1:0]  ch_r, ch_nxt;
  logic                         clr;
  logic                         acc;
  logic                         is_cr;
  logic                         is_lf;

  assign acc   = in_valid && (state_r == tlts_pkg::S_IDLE);
  assign is_cr = (in_char_in == tlts_pkg::CR_CHAR);
  assign is_lf = (in_char_in == tlts_pkg::LF_CHAR);

  // Next state: walk the command sequence one word per taken slot
  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    cursor_nxt = cursor_r;
    base_nxt   = base_r;
    ch_nxt     = ch_r;
    clr        = 1'b0;
    unique case (state_r)
      tlts_pkg::S_IDLE: begin
        if (acc) begin
          priority if (is_cr) begin
            state_nxt = tlts_pkg::S_IDLE;
          end else if (is_lf) begin
            base_nxt   = ~base_r;
            clr        = 1'b1;
            cursor_nxt = '0;
            state_nxt  = tlts_pkg::S_R0_POS;
          end else begin
            ch_nxt    = in_char_in;
            state_nxt = tlts_pkg::S_CUR_POS;
          end
        end
      end
      tlts_pkg::S_CUR_POS: begin
        if (take) begin
          state_nxt = tlts_pkg::S_CUR_CHAR;
        end
      end
      tlts_pkg::S_CUR_CHAR: begin
        if (take) begin
          if (cursor_r == tlts_pkg::LAST_COL) begin
            base_nxt   = ~base_r;
            clr        = 1'b1;
            cursor_nxt = '0;
            state_nxt  = tlts_pkg::S_R0_POS;
          end else begin
            cursor_nxt = cursor_r + 1'b1;
            state_nxt  = tlts_pkg::S_END_POS;
          end
        end
      end
      tlts_pkg::S_R0_POS: begin
        if (take) begin
          col_nxt   = '0;
          state_nxt = tlts_pkg::S_R0_CHAR;
        end
      end
      tlts_pkg::S_R0_CHAR: begin
        if (take) begin
          if (col_r == tlts_pkg::LAST_COL) begin
            state_nxt = tlts_pkg::S_R1_POS;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      tlts_pkg::S_R1_POS: begin
        if (take) begin
          col_nxt   = '0;
          state_nxt = tlts_pkg::S_R1_CHAR;
        end
      end
      tlts_pkg::S_R1_CHAR: begin
        if (take) begin
          if (col_r == tlts_pkg::LAST_COL) begin
            state_nxt = tlts_pkg::S_END_POS;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      tlts_pkg::S_END_POS: begin
        if (take) begin
          state_nxt = tlts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlts_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: command word of the current state, store control
  always_comb begin
    cmd          = '0;
    cmd_valid    = (state_r != tlts_pkg::S_IDLE);
    in_stall     = (state_r != tlts_pkg::S_IDLE);
    unique case (state_r)
      tlts_pkg::S_CUR_POS: begin
        cmd.command = tlts_pkg::CMD_SET_POS;
        cmd.column  = tlts_pkg::col_field(cursor_r);
        cmd.row     = 1'b1;
      end
      tlts_pkg::S_CUR_CHAR: begin
        cmd.command  = tlts_pkg::CMD_WRITE;
        cmd.char_out = ch_r;
      end
      tlts_pkg::S_R0_POS: begin
        cmd.command = tlts_pkg::CMD_SET_POS;
      end
      tlts_pkg::S_R1_POS: begin
        cmd.command = tlts_pkg::CMD_SET_POS;
        cmd.row     = 1'b1;
      end
      tlts_pkg::S_R0_CHAR, tlts_pkg::S_R1_CHAR: begin
        cmd.command  = tlts_pkg::CMD_WRITE;
        cmd.char_out = rd_char;
      end
      tlts_pkg::S_END_POS: begin
        cmd.command = tlts_pkg::CMD_SET_POS;
        cmd.column  = tlts_pkg::col_field(cursor_r);
        cmd.row     = 1'b1;
        cmd.last    = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase

    // Bottom row is the physical row opposite base; scroll clears the old top
    st_ctl.we      = acc && !is_cr && !is_lf;
    st_ctl.waddr   = tlts_pkg::entry_addr(~base_r, cursor_r);
    st_ctl.wdata   = in_char_in;
    st_ctl.clr     = clr;
    st_ctl.clr_row = base_r;
    st_ctl.raddr   = tlts_pkg::entry_addr(
                       (state_nxt == tlts_pkg::S_R0_CHAR) ? base_nxt : ~base_nxt, col_nxt);
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tlts_pkg::S_IDLE;
      col_r    <= '0;
      cursor_r <= '0;
      base_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      cursor_r <= cursor_nxt;
      base_r   <= base_nxt;
    end
  end

  // Hold the typed character for its write command
  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  `TLTS_ASSERT_NEXT(a_print_starts, acc && !is_cr && !is_lf, state_r == tlts_pkg::S_CUR_POS, "printable word did not start its command walk")
  `TLTS_ASSERT_NEXT(a_cr_silent, acc && is_cr, state_r == tlts_pkg::S_IDLE && $stable(cursor_r), "carriage return changed state")
  `TLTS_ASSERT_NEXT(a_scroll_flips, clr, base_r != $past(base_r) && cursor_r == '0, "scroll did not swap rows and home the cursor")
  `TLTS_ASSERT_NOW(a_last_on_end, cmd_valid && cmd.last, state_r == tlts_pkg::S_END_POS, "last flag outside final command")

endmodule

@@ hw/rtl/two_line_text_terminal_scroller_unit.sv @@
// Top level of the two-row text terminal scroller with output register.
// Takes one character word at a time and emits display command words: a
// carriage return gives none, a printable character gives 3 (set position,
// write, set position) and 37 when it fills the bottom row, a newline gives
// 35. Commands leave at one per cycle while out_stall is low; in_stall stays
// high until the final command (out_last) has been loaded into the output
// register. Rendered characters come from a 32-entry text memory with a
// registered read; scrolling swaps the physical rows and clears the new
// bottom row in the same cycle.
module two_line_text_terminal_scroller_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [tlts_pkg::CHAR_W-1:0]         in_char_in,
  output logic                                in_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_command,
  output logic [tlts_pkg::COL_FIELD_W-1:0]    out_column,
  output logic                                out_row,
  output logic [tlts_pkg::CHAR_W-1:0]         out_char_out,
  output logic                                out_last
);

  tlts_pkg::st_ctl_t           st_ctl;
  tlts_pkg::cmd_t              cmd;
  tlts_pkg::cmd_t              out_cmd_r;
  logic                        cmd_valid;
  logic                        take;
  logic [tlts_pkg::CHAR_W-1:0] rd_char;
  logic                        out_valid_r, out_valid_nxt;

  tlts_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .rd_char (rd_char)
  );

  tlts_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_char_in (in_char_in),
    .in_stall   (in_stall),
    .take       (take),
    .rd_char    (rd_char),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .st_ctl     (st_ctl)
  );

  // Load a new word when the output register is empty or being drained
  assign take          = !out_valid_r || !out_stall;
  assign out_valid_nxt = take ? cmd_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (take && cmd_valid) begin
      out_cmd_r <= cmd;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_command  = out_cmd_r.command;
  assign out_column   = out_cmd_r.column;
  assign out_row      = out_cmd_r.row;
  assign out_char_out = out_cmd_r.char_out;
  assign out_last     = out_cmd_r.last;

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the two-row text terminal scroller: directed and random character traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_WAIT  = 50;
  localparam int RANDOM_WORDS = 480;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic [tlts_pkg::CHAR_W-1:0]          in_char_in = '0;
  logic                                 in_stall;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 out_command;
  logic [tlts_pkg::COL_FIELD_W-1:0]     out_column;
  logic                                 out_row;
  logic [tlts_pkg::CHAR_W-1:0]          out_char_out;
  logic                                 out_last;

  // Shadow of the display text and the bottom-row cursor
  logic [tlts_pkg::CHAR_W-1:0] screen_text [0:tlts_pkg::DEPTH-1];
  int                          bottom_cursor;
  // Display commands still to come, oldest first
  tlts_pkg::cmd_t              cmd_expect [$];
  int                          err_count = 0;
  bit                          idle_on = 1'b1;
  int                          quiet_cycles = 0;

  two_line_text_terminal_scroller_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_in   (in_char_in),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_command  (out_command),
    .out_column   (out_column),
    .out_row      (out_row),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue a set-position command
  task automatic push_pos(input int col, input int row, input bit is_last);
    tlts_pkg::cmd_t w;
    w.command  = tlts_pkg::CMD_SET_POS;
    w.column   = tlts_pkg::COL_FIELD_W'(col);
    w.row      = row[0];
    w.char_out = '0;
    w.last     = is_last;
    cmd_expect.push_back(w);
  endtask

  // Queue a write-character command
  task automatic push_write(input logic [tlts_pkg::CHAR_W-1:0] ch);
    tlts_pkg::cmd_t w;
    w.command  = tlts_pkg::CMD_WRITE;
    w.column   = '0;
    w.row      = 1'b0;
    w.char_out = ch;
    w.last     = 1'b0;
    cmd_expect.push_back(w);
  endtask

  task automatic render_row(input int row);
    push_pos(0, row, 1'b0);
    for (int c = 0; c < tlts_pkg::COLUMNS; c++) begin
      push_write(screen_text[row * tlts_pkg::COLUMNS + c]);
    end
  endtask

  // Move the bottom row up, blank it, and redraw both rows
  task automatic scroll_text();
    for (int c = 0; c < tlts_pkg::COLUMNS; c++) begin
      screen_text[c] = screen_text[tlts_pkg::COLUMNS + c];
      screen_text[tlts_pkg::COLUMNS + c] = tlts_pkg::SPACE_CHAR;
    end
    render_row(0);
    render_row(1);
  endtask

  // Work out the commands that one accepted character word causes
  task automatic predict_char(input logic [tlts_pkg::CHAR_W-1:0] ch);
    if (bottom_cursor >= tlts_pkg::COLUMNS) bottom_cursor = 0;
    if (ch == tlts_pkg::CR_CHAR) return;
    if (ch == tlts_pkg::LF_CHAR) begin
      scroll_text();
      bottom_cursor = 0;
      push_pos(0, 1, 1'b1);
    end else begin
      screen_text[tlts_pkg::COLUMNS + bottom_cursor] = ch;
      push_pos(bottom_cursor, 1, 1'b0);
      push_write(ch);
      bottom_cursor++;
      if (bottom_cursor >= tlts_pkg::COLUMNS) begin
        scroll_text();
        bottom_cursor = 0;
      end
      push_pos(bottom_cursor, 1, 1'b1);
    end
  endtask

  // Offer one character word and wait until it is taken
  task automatic send_char(input logic [tlts_pkg::CHAR_W-1:0] ch);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    do @(posedge clk); while (in_stall);
    predict_char(ch);
  endtask

  // Hold the input until every expected command has arrived, then let the block settle
  task automatic wait_display_idle();
    in_valid <= 1'b0;
    while (cmd_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic test_single_chars();
    logic [tlts_pkg::CHAR_W-1:0] seq [7];
    seq = '{tlts_pkg::CR_CHAR, 8'h41, 8'h00, 8'hFF, tlts_pkg::LF_CHAR, tlts_pkg::LF_CHAR,
            tlts_pkg::CR_CHAR};
    foreach (seq[i]) send_char(seq[i]);
    wait_display_idle();
  endtask

  // Fill the bottom row so the last character scrolls; use codes next to CR and LF
  task automatic test_row_fill();
    logic [tlts_pkg::CHAR_W-1:0] seq [16];
    seq = '{8'h20, 8'h0C, 8'h0B, 8'h0E, 8'h09, 8'h80, 8'h8D, 8'h8A,
            8'h7F, 8'h7E, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h30, 8'h5A};
    foreach (seq[i]) send_char(seq[i]);
    wait_display_idle();
  endtask

  task automatic send_random_words(input int count);
    int sent;
    int pick;
    logic [tlts_pkg::CHAR_W-1:0] ch;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) ch = tlts_pkg::LF_CHAR;
      else if (pick < 13) ch = tlts_pkg::CR_CHAR;
      else if (pick < 65) ch = tlts_pkg::CHAR_W'($urandom_range(32, 126));
      else ch = tlts_pkg::CHAR_W'($urandom);
      send_char(ch);
      sent++;
    end
  endtask

  // Random text, with a stretch of back-to-back traffic; the display drains after the first and last phases
  task automatic test_random_traffic();
    idle_on = 1'b1;
    send_random_words(RANDOM_WORDS * 2 / 5);
    wait_display_idle();
    idle_on = 1'b0;
    send_random_words(RANDOM_WORDS / 5);
    idle_on = 1'b1;
    send_random_words(RANDOM_WORDS * 2 / 5);
    wait_display_idle();
  endtask

  // Stall the command side at random and check each command word taken
  initial begin : command_monitor
    int             n;
    tlts_pkg::cmd_t want;
    wait (rst_n === 1'b1);
    forever begin
      n = idle_on ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (cmd_expect.size() == 0) begin
        $error("unexpected command word: command=%0d column=%0d row=%0d char_out=%0h",
               out_command, out_column, out_row, out_char_out);
        err_count++;
      end else begin
        want = cmd_expect.pop_front();
        if (out_command !== want.command) begin
          $error("command: expected %0d, actual %0d", want.command, out_command);
          err_count++;
        end
        if (out_column !== want.column) begin
          $error("column: expected %0d, actual %0d", want.column, out_column);
          err_count++;
        end
        if (out_row !== want.row) begin
          $error("row: expected %0d, actual %0d", want.row, out_row);
          err_count++;
        end
        if (out_char_out !== want.char_out) begin
          $error("char_out: expected %0h, actual %0h", want.char_out, out_char_out);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  // Drop the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < tlts_pkg::DEPTH; i++) screen_text[i] = tlts_pkg::SPACE_CHAR;
    bottom_cursor = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_chars();
    test_row_fill();
    test_random_traffic();

    if (err_count == 0 && cmd_expect.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
